// ----- hdl/rcmps_pkg.sv -----
// Shared types, constants and codes of the region column mean profile unit.
package rcmps_pkg;

    localparam int PIX_W      = 8;
    localparam int FRAME_W    = 13;
    localparam int START_W    = 12;
    localparam int COLIDX_W   = 12;
    localparam int MEAN_W     = 16;
    localparam int QUO_W      = 16;
    localparam int NUM_CH     = 4;
    localparam int CH_W       = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    // BT.601 luma: floor((299 R + 587 G + 114 B) / 1000), the divide done as a
    // multiply by ceil(2^28 / 1000) and a shift, exact over the whole range.
    localparam int WSUM_W  = 18;
    localparam int RECIP_W = 19;
    localparam int LUMA_SH = 28;
    localparam logic [9:0] LUMA_WR = 10'd299;
    localparam logic [9:0] LUMA_WG = 10'd587;
    localparam logic [9:0] LUMA_WB = 10'd114;
    localparam logic [RECIP_W-1:0] LUMA_RECIP = 19'd268436;

    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 13'd4096;
    localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 13'd4096;
    localparam logic [START_W-1:0] RST_ROI_LEFT     = 12'd0;
    localparam logic [START_W-1:0] RST_ROI_TOP      = 12'd0;
    localparam logic [FRAME_W-1:0] RST_ROI_COLUMNS  = 13'd256;
    localparam logic [FRAME_W-1:0] RST_ROI_ROWS     = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_ROI_LEFT     = 3'd2,
        REG_ROI_TOP      = 3'd3,
        REG_ROI_COLUMNS  = 3'd4,
        REG_ROI_ROWS     = 3'd5
    } t_reg_idx;

    localparam logic REC_COLUMN = 1'b0;
    localparam logic REC_STAT   = 1'b1;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CH_W-1:0] CH_LUMA  = 2'd3;

    typedef struct packed {
        logic                record_kind;
        logic [COLIDX_W-1:0] column_index;
        logic [CH_W-1:0]     channel;
        logic [MEAN_W-1:0]   mean_red;
        logic [MEAN_W-1:0]   mean_green;
        logic [MEAN_W-1:0]   mean_blue;
        logic [MEAN_W-1:0]   mean_luma;
        logic [MEAN_W-1:0]   stat_max;
        logic [MEAN_W-1:0]   stat_min;
        logic [MEAN_W-1:0]   stat_avg;
        logic                last;
    } t_rec;

    typedef struct packed {
        logic            clear;
        logic            pix_load;
        logic            div_start;
        logic            div_sel_avg;
        logic            mean_store;
        logic            stat_upd;
        logic            col_rec_load;
        logic            col_next;
        logic            stat_rec_load;
        logic [CH_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic row_last;
        logic col_last;
        logic div_done;
        logic out_free;
    } t_sts;

    typedef enum logic [3:0] {
        S_PIX,
        S_DRAIN,
        S_DIV_START,
        S_DIV_WAIT,
        S_STAT_UPD,
        S_COL_OUT,
        S_AVG_START,
        S_AVG_WAIT,
        S_STAT_OUT
    } t_state;

endpackage

// ----- hdl/rcmps_pix_if.sv -----
// Pixel request channel: one RGB pixel per request.
interface rcmps_pix_if import rcmps_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hdl/rcmps_rec_if.sv -----
// Record request channel: column mean records and channel statistics records.
interface rcmps_rec_if import rcmps_pkg::*;;
    logic                valid;
    logic                ready;
    logic                record_kind;
    logic [COLIDX_W-1:0] column_index;
    logic [CH_W-1:0]     channel;
    logic [MEAN_W-1:0]   mean_red;
    logic [MEAN_W-1:0]   mean_green;
    logic [MEAN_W-1:0]   mean_blue;
    logic [MEAN_W-1:0]   mean_luma;
    logic [MEAN_W-1:0]   stat_max;
    logic [MEAN_W-1:0]   stat_min;
    logic [MEAN_W-1:0]   stat_avg;
    logic                last;

    modport source (
        output valid, output record_kind, output column_index, output channel,
        output mean_red, output mean_green, output mean_blue, output mean_luma,
        output stat_max, output stat_min, output stat_avg, output last,
        input ready
    );
    modport sink (
        input valid, input record_kind, input column_index, input channel,
        input mean_red, input mean_green, input mean_blue, input mean_luma,
        input stat_max, input stat_min, input stat_avg, input last,
        output ready
    );
endinterface

// ----- hdl/rcmps_cfg.sv -----
// Configuration registers and clamping of the region to the frame.
module rcmps_cfg import rcmps_pkg::*; #(
    parameter int MAX_SIDE = 4096,
    localparam int LEN_W = $clog2(MAX_SIDE + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output logic                  o_clear,
    output logic [LEN_W-1:0]      o_cols,
    output logic [LEN_W-1:0]      o_rows
);

    localparam int CW = (LEN_W > FRAME_W) ? LEN_W : FRAME_W;

    logic [FRAME_W-1:0] r_frame_width, r_frame_height, r_roi_columns, r_roi_rows;
    logic [START_W-1:0] r_roi_left, r_roi_top;
    logic               known;

    // Saturate the frame side, pull the start inside it, then trim the length.
    function automatic logic [LEN_W-1:0] clamp_span(
        input logic [FRAME_W-1:0] frame,
        input logic [START_W-1:0] start,
        input logic [FRAME_W-1:0] len
    );
        logic [CW-1:0] f, s, l, room;
        f = CW'(frame);
        s = CW'(start);
        l = CW'(len);
        if (f == '0) f = CW'(1);
        if (f > CW'(MAX_SIDE)) f = CW'(MAX_SIDE);
        if (s > f - CW'(1)) s = f - CW'(1);
        room = f - s;
        if (l > room) l = room;
        return LEN_W'(l);
    endfunction

    always_comb begin
        unique case (i_index) inside
            REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_ROI_LEFT,
            REG_ROI_TOP, REG_ROI_COLUMNS, REG_ROI_ROWS: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign o_clear = i_we && known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_roi_left     <= RST_ROI_LEFT;
            r_roi_top      <= RST_ROI_TOP;
            r_roi_columns  <= RST_ROI_COLUMNS;
            r_roi_rows     <= RST_ROI_ROWS;
        end else if (i_we) begin
            unique case (i_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_data;
                REG_ROI_LEFT:     r_roi_left     <= i_data[START_W-1:0];
                REG_ROI_TOP:      r_roi_top      <= i_data[START_W-1:0];
                REG_ROI_COLUMNS:  r_roi_columns  <= i_data;
                REG_ROI_ROWS:     r_roi_rows     <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cols = clamp_span(r_frame_width, r_roi_left, r_roi_columns);
    assign o_rows = clamp_span(r_frame_height, r_roi_top, r_roi_rows);

endmodule

// ----- hdl/rcmps_div.sv -----
// Restoring divider, one quotient bit per cycle, for quotients known to fit.
module rcmps_div import rcmps_pkg::*; #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [QUO_W-1:0] r_sh, n_sh;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DVS_W:0]   trial;
    logic             ge;

    // The upper part of the dividend is below the divisor, so the partial
    // remainder always fits the divisor width.
    always_comb begin
        trial = {r_rem, r_sh[QUO_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        n_rem = ge ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
        n_sh  = {r_sh[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVS_W'(i_dividend >> QUO_W);
            r_sh  <= i_dividend[QUO_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= n_sh;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

// ----- hdl/rcmps_dp.sv -----
// Datapath: luma, column sums, position counters, statistics and record register.
module rcmps_dp import rcmps_pkg::*; #(
    parameter int MAX_SIDE = 4096,
    localparam int LEN_W = $clog2(MAX_SIDE + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [LEN_W-1:0] i_cols,
    input  logic [LEN_W-1:0] i_rows,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output t_rec             o_rec,
    output logic             o_rec_valid,
    input  logic             i_rec_ready
);

    localparam int CNT_W  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int SUM_W  = PIX_W + LEN_W;
    localparam int TOT_W  = MEAN_W + LEN_W;
    localparam int PROD_W = WSUM_W + RECIP_W;

    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_red, r_green, r_blue;
    logic [WSUM_W-1:0]  r_wsum, n_wsum;
    logic [PROD_W-1:0]  prod;
    logic [PIX_W-1:0]   s1_px [NUM_CH];
    logic [CNT_W-1:0]   r_row, r_col;
    logic [SUM_W-1:0]   r_sum   [NUM_CH];
    logic [MEAN_W-1:0]  r_mean  [NUM_CH];
    logic [MEAN_W-1:0]  r_max   [NUM_CH];
    logic [MEAN_W-1:0]  r_min   [NUM_CH];
    logic [TOT_W-1:0]   r_total [NUM_CH];
    t_rec               r_rec, n_rec;
    logic               r_rec_valid;
    logic [TOT_W-1:0]   div_dvd;
    logic [LEN_W-1:0]   div_dvs;
    logic               div_done;
    logic [QUO_W-1:0]   div_quot;

    assign n_wsum = WSUM_W'(LUMA_WR) * WSUM_W'(i_red)
                  + WSUM_W'(LUMA_WG) * WSUM_W'(i_green)
                  + WSUM_W'(LUMA_WB) * WSUM_W'(i_blue);

    assign prod = PROD_W'(r_wsum) * PROD_W'(LUMA_RECIP);

    assign s1_px[0] = r_red;
    assign s1_px[1] = r_green;
    assign s1_px[2] = r_blue;
    assign s1_px[3] = prod[LUMA_SH +: PIX_W];

    assign o_sts.empty    = (i_cols == '0) || (i_rows == '0);
    assign o_sts.row_last = LEN_W'(r_row) == i_rows - LEN_W'(1);
    assign o_sts.col_last = LEN_W'(r_col) == i_cols - LEN_W'(1);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_rec_valid || i_rec_ready;

    assign div_dvd = i_cmd.div_sel_avg ? r_total[i_cmd.ch] : {r_sum[i_cmd.ch], {PIX_W{1'b0}}};
    assign div_dvs = i_cmd.div_sel_avg ? i_cols : i_rows;

    rcmps_div #(
        .DVD_W (TOT_W),
        .DVS_W (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Next record: a column record, a channel statistics record, or unchanged.
    always_comb begin
        n_rec = r_rec;
        if (i_cmd.col_rec_load) begin
            n_rec              = '0;
            n_rec.record_kind  = REC_COLUMN;
            n_rec.column_index = COLIDX_W'(r_col);
            n_rec.channel      = CH_RED;
            n_rec.mean_red     = r_mean[0];
            n_rec.mean_green   = r_mean[1];
            n_rec.mean_blue    = r_mean[2];
            n_rec.mean_luma    = r_mean[3];
        end else if (i_cmd.stat_rec_load) begin
            n_rec             = '0;
            n_rec.record_kind = REC_STAT;
            n_rec.channel     = i_cmd.ch;
            n_rec.stat_max    = r_max[i_cmd.ch];
            n_rec.stat_min    = r_min[i_cmd.ch];
            n_rec.stat_avg    = div_quot;
            n_rec.last        = i_cmd.ch == CH_LUMA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_rec_valid <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c]   <= '0;
                r_max[c]   <= '0;
                r_min[c]   <= '0;
                r_total[c] <= '0;
            end
        end else begin
            r_s1_valid <= i_cmd.pix_load && !i_cmd.clear;

            if (i_cmd.clear) begin
                r_row <= '0;
            end else if (i_cmd.pix_load) begin
                r_row <= o_sts.row_last ? '0 : r_row + CNT_W'(1);
            end

            if (i_cmd.clear) begin
                r_col <= '0;
            end else if (i_cmd.col_next) begin
                r_col <= r_col + CNT_W'(1);
            end

            for (int c = 0; c < NUM_CH; c++) begin
                if (i_cmd.clear || i_cmd.stat_upd) begin
                    r_sum[c] <= '0;
                end else if (r_s1_valid) begin
                    r_sum[c] <= r_sum[c] + SUM_W'(s1_px[c]);
                end

                if (i_cmd.clear) begin
                    r_max[c]   <= '0;
                    r_min[c]   <= '0;
                    r_total[c] <= '0;
                end else if (i_cmd.stat_upd) begin
                    if (r_mean[c] > r_max[c]) r_max[c] <= r_mean[c];
                    if (r_col == '0 || r_mean[c] < r_min[c]) r_min[c] <= r_mean[c];
                    r_total[c] <= r_total[c] + TOT_W'(r_mean[c]);
                end
            end

            if (i_cmd.col_rec_load || i_cmd.stat_rec_load) begin
                r_rec_valid <= 1'b1;
            end else if (i_rec_ready) begin
                r_rec_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_load) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_wsum  <= n_wsum;
        end

        if (i_cmd.mean_store) begin
            r_mean[i_cmd.ch] <= div_quot;
        end

        r_rec <= n_rec;
    end

    assign o_rec       = r_rec;
    assign o_rec_valid = r_rec_valid;

endmodule

// ----- hdl/rcmps_ctrl.sv -----
// Controller: sequences pixel intake, column-end divisions and record output.
module rcmps_ctrl import rcmps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clear,
    input  logic i_pix_valid,
    output logic o_pix_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_ch, n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PIX;
            r_ch    <= CH_RED;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    assign o_pix_ready = r_state == S_PIX;

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        o_cmd    = '0;
        o_cmd.ch = r_ch;
        if (i_clear) begin
            o_cmd.clear = 1'b1;
            n_state     = S_PIX;
            n_ch        = CH_RED;
        end else begin
            unique case (r_state)
                S_PIX: begin
                    if (i_pix_valid && !i_sts.empty) begin
                        o_cmd.pix_load = 1'b1;
                        if (i_sts.row_last) n_state = S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    n_state = S_DIV_START;
                end
                S_DIV_START: begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_sts.div_done) begin
                        o_cmd.mean_store = 1'b1;
                        if (r_ch == CH_LUMA) begin
                            n_ch    = CH_RED;
                            n_state = S_STAT_UPD;
                        end else begin
                            n_ch    = r_ch + CH_W'(1);
                            n_state = S_DIV_START;
                        end
                    end
                end
                S_STAT_UPD: begin
                    o_cmd.stat_upd = 1'b1;
                    n_state        = S_COL_OUT;
                end
                S_COL_OUT: begin
                    if (i_sts.out_free) begin
                        o_cmd.col_rec_load = 1'b1;
                        if (i_sts.col_last) begin
                            n_state = S_AVG_START;
                        end else begin
                            o_cmd.col_next = 1'b1;
                            n_state        = S_PIX;
                        end
                    end
                end
                S_AVG_START: begin
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_avg = 1'b1;
                    n_state           = S_AVG_WAIT;
                end
                S_AVG_WAIT: begin
                    if (i_sts.div_done) n_state = S_STAT_OUT;
                end
                S_STAT_OUT: begin
                    if (i_sts.out_free) begin
                        o_cmd.stat_rec_load = 1'b1;
                        if (r_ch == CH_LUMA) begin
                            o_cmd.clear = 1'b1;
                            n_ch        = CH_RED;
                            n_state     = S_PIX;
                        end else begin
                            n_ch    = r_ch + CH_W'(1);
                            n_state = S_AVG_START;
                        end
                    end
                end
                default: begin
                    n_state = S_PIX;
                end
            endcase
        end
    end

endmodule

// ----- hdl/roi_column_mean_profile_stats_unit.sv -----
// Top level of the region column mean profile unit with BT.601 luma statistics.
// Throughput: one pixel request per cycle within a column of the region.
// After the last pixel of a column the input is held off while the shared
// 16-step divider forms four means; region end adds four divisions for averages.
// Reset (synchronous, active low) restores the default region and clears progress.
module roi_column_mean_profile_stats_unit import rcmps_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rcmps_pix_if.sink             i_pix,
    rcmps_rec_if.source           o_rec
);

    localparam int LEN_W = $clog2(MAX_SIDE + 1);

    logic             cfg_clear;
    logic [LEN_W-1:0] cols, rows;
    t_cmd             cmd;
    t_sts             sts;
    t_rec             rec;
    logic             rec_valid;
    logic             pix_ready;

    // The register file clamps the region to the frame every cycle. Any write
    // to a known register abandons a partly taken region.
    rcmps_cfg #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_clear (cfg_clear),
        .o_cols  (cols),
        .o_rows  (rows)
    );

    // The controller takes pixel requests while no column end is in progress.
    // At a column end it drains the luma stage, runs four divisions for the
    // means, updates the statistics and queues the column record. At the end
    // of the region it runs four more divisions for the averages and queues
    // the four channel records, the luma record marked last.
    rcmps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_clear),
        .i_pix_valid (i_pix.valid),
        .o_pix_ready (pix_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath keeps a one-deep record register, so pixels of the next
    // column are taken while a column record still waits for the sink.
    rcmps_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cols      (cols),
        .i_rows      (rows),
        .i_red       (i_pix.red),
        .i_green     (i_pix.green),
        .i_blue      (i_pix.blue),
        .o_rec       (rec),
        .o_rec_valid (rec_valid),
        .i_rec_ready (o_rec.ready)
    );

    assign i_pix.ready = pix_ready;

    assign o_rec.valid        = rec_valid;
    assign o_rec.record_kind  = rec.record_kind;
    assign o_rec.column_index = rec.column_index;
    assign o_rec.channel      = rec.channel;
    assign o_rec.mean_red     = rec.mean_red;
    assign o_rec.mean_green   = rec.mean_green;
    assign o_rec.mean_blue    = rec.mean_blue;
    assign o_rec.mean_luma    = rec.mean_luma;
    assign o_rec.stat_max     = rec.stat_max;
    assign o_rec.stat_min     = rec.stat_min;
    assign o_rec.stat_avg     = rec.stat_avg;
    assign o_rec.last         = rec.last;

endmodule

// ----- hdl/rcmps_chk.sv -----
// Port-level assertions on the record channel, bound to the top level.
module rcmps_chk import rcmps_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic                i_kind,
    input logic [COLIDX_W-1:0] i_col_idx,
    input logic [CH_W-1:0]     i_channel,
    input logic [MEAN_W-1:0]   i_mean_r,
    input logic [MEAN_W-1:0]   i_mean_g,
    input logic [MEAN_W-1:0]   i_mean_b,
    input logic [MEAN_W-1:0]   i_mean_y,
    input logic [MEAN_W-1:0]   i_max,
    input logic [MEAN_W-1:0]   i_min,
    input logic [MEAN_W-1:0]   i_avg,
    input logic                i_last
);

    a_rec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_kind, i_col_idx, i_channel,
            i_mean_r, i_mean_g, i_mean_b, i_mean_y, i_max, i_min, i_avg, i_last}))
        else $error("record changed while stalled");

    a_col_rec_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == REC_COLUMN |->
            i_channel == CH_RED && i_max == '0 && i_min == '0 && i_avg == '0 && !i_last)
        else $error("column record carries statistics fields");

    a_last_is_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> i_kind == REC_STAT && i_channel == CH_LUMA)
        else $error("last flag on a record other than the luma statistics");

    a_stat_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == REC_STAT |->
            i_min <= i_avg && i_avg <= i_max && i_col_idx == '0
            && i_mean_r == '0 && i_mean_g == '0 && i_mean_b == '0 && i_mean_y == '0)
        else $error("statistics record out of order or with stray fields");

endmodule

bind roi_column_mean_profile_stats_unit rcmps_chk u_rcmps_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_rec.valid),
    .i_ready   (o_rec.ready),
    .i_kind    (o_rec.record_kind),
    .i_col_idx (o_rec.column_index),
    .i_channel (o_rec.channel),
    .i_mean_r  (o_rec.mean_red),
    .i_mean_g  (o_rec.mean_green),
    .i_mean_b  (o_rec.mean_blue),
    .i_mean_y  (o_rec.mean_luma),
    .i_max     (o_rec.stat_max),
    .i_min     (o_rec.stat_min),
    .i_avg     (o_rec.stat_avg),
    .i_last    (o_rec.last)
);

// ----- dv/rcmps_profile_checker.sv -----
// Checker of the region column mean profile unit: predicts records from requests and compares.
module rcmps_profile_checker import rcmps_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rcmps_pix_if                  i_pix,
    rcmps_rec_if                  i_rec,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the geometry registers, as written.
    logic [FRAME_W-1:0] frame_w;
    logic [FRAME_W-1:0] frame_h;
    logic [START_W-1:0] start_col;
    logic [START_W-1:0] start_row;
    logic [FRAME_W-1:0] span_cols;
    logic [FRAME_W-1:0] span_rows;

    // Progress through the region and the running channel statistics.
    int unsigned     row_pos;
    int unsigned     col_pos;
    int unsigned     col_sum  [NUM_CH];
    int unsigned     ch_max   [NUM_CH];
    int unsigned     ch_min   [NUM_CH];
    longint unsigned ch_total [NUM_CH];

    t_rec profile_q [$];
    int   mismatches = 0;

    function automatic int unsigned axis_span(int unsigned frame, int unsigned start,
                                              int unsigned len);
        int unsigned f;
        int unsigned s;
        f = (frame < 1) ? 1 : frame;
        if (f > MAX_SIDE) f = MAX_SIDE;
        s = (start > f - 1) ? f - 1 : start;
        return (len > f - s) ? f - s : len;
    endfunction

    task automatic clear_profile();
        row_pos = 0;
        col_pos = 0;
        for (int c = 0; c < NUM_CH; c++) begin
            col_sum[c]  = 0;
            ch_max[c]   = 0;
            ch_min[c]   = 0;
            ch_total[c] = 0;
        end
    endtask

    // Accumulates one pixel and queues the records it completes.
    task automatic absorb_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                input logic [PIX_W-1:0] b);
        int unsigned n_cols;
        int unsigned n_rows;
        int unsigned sample [NUM_CH];
        int unsigned mean   [NUM_CH];
        t_rec        rec;
        n_cols = axis_span(frame_w, start_col, span_cols);
        n_rows = axis_span(frame_h, start_row, span_rows);
        if (n_cols == 0 || n_rows == 0) return;

        sample[CH_RED]   = r;
        sample[CH_GREEN] = g;
        sample[CH_BLUE]  = b;
        sample[CH_LUMA]  = (299 * sample[CH_RED] + 587 * sample[CH_GREEN]
                            + 114 * sample[CH_BLUE]) / 1000;
        for (int c = 0; c < NUM_CH; c++) col_sum[c] += sample[c];

        if (row_pos + 1 < n_rows) begin
            row_pos++;
            return;
        end

        for (int c = 0; c < NUM_CH; c++) begin
            mean[c] = (col_sum[c] << 8) / n_rows;
            if (mean[c] > ch_max[c]) ch_max[c] = mean[c];
            if (col_pos == 0 || mean[c] < ch_min[c]) ch_min[c] = mean[c];
            ch_total[c] += mean[c];
            col_sum[c] = 0;
        end
        row_pos = 0;

        rec              = '0;
        rec.record_kind  = REC_COLUMN;
        rec.column_index = COLIDX_W'(col_pos);
        rec.mean_red     = MEAN_W'(mean[CH_RED]);
        rec.mean_green   = MEAN_W'(mean[CH_GREEN]);
        rec.mean_blue    = MEAN_W'(mean[CH_BLUE]);
        rec.mean_luma    = MEAN_W'(mean[CH_LUMA]);
        profile_q.push_back(rec);

        if (col_pos + 1 < n_cols) begin
            col_pos++;
            return;
        end

        for (int c = 0; c < NUM_CH; c++) begin
            rec             = '0;
            rec.record_kind = REC_STAT;
            rec.channel     = CH_W'(c);
            rec.stat_max    = MEAN_W'(ch_max[c]);
            rec.stat_min    = MEAN_W'(ch_min[c]);
            rec.stat_avg    = MEAN_W'(ch_total[c] / n_cols);
            rec.last        = (rec.channel == CH_LUMA);
            profile_q.push_back(rec);
        end
        clear_profile();
    endtask

    function automatic string rec_text(t_rec r);
        return $sformatf({"kind=%0d col=%0d ch=%0d means=%0d/%0d/%0d/%0d",
                          " max=%0d min=%0d avg=%0d last=%0d"},
                         r.record_kind, r.column_index, r.channel, r.mean_red,
                         r.mean_green, r.mean_blue, r.mean_luma, r.stat_max,
                         r.stat_min, r.stat_avg, r.last);
    endfunction

    function automatic bit same_record(t_rec want, t_rec got);
        return got.record_kind  === want.record_kind  &&
               got.column_index === want.column_index &&
               got.channel      === want.channel      &&
               got.mean_red     === want.mean_red     &&
               got.mean_green   === want.mean_green   &&
               got.mean_blue    === want.mean_blue    &&
               got.mean_luma    === want.mean_luma    &&
               got.stat_max     === want.stat_max     &&
               got.stat_min     === want.stat_min     &&
               got.stat_avg     === want.stat_avg     &&
               got.last         === want.last;
    endfunction

    task automatic note_mismatch(input string why, input string want_txt, input t_rec got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch %0d at %0t: %s", mismatches, $time, why);
            $display("  expected %s", want_txt);
            $display("  actual   %s", rec_text(got));
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rec got;
        t_rec want;
        if (!i_rst_n) begin
            frame_w   = RST_FRAME_WIDTH;
            frame_h   = RST_FRAME_HEIGHT;
            start_col = RST_ROI_LEFT;
            start_row = RST_ROI_TOP;
            span_cols = RST_ROI_COLUMNS;
            span_rows = RST_ROI_ROWS;
            clear_profile();
            profile_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  frame_w   = i_cfg_data;
                    REG_FRAME_HEIGHT: frame_h   = i_cfg_data;
                    REG_ROI_LEFT:     start_col = i_cfg_data[START_W-1:0];
                    REG_ROI_TOP:      start_row = i_cfg_data[START_W-1:0];
                    REG_ROI_COLUMNS:  span_cols = i_cfg_data;
                    REG_ROI_ROWS:     span_rows = i_cfg_data;
                    default: ;
                endcase
                // Only a write to a real register drops the partial region.
                if (i_cfg_index <= REG_ROI_ROWS) clear_profile();
            end
            if (i_pix.valid === 1'b1 && i_pix.ready === 1'b1)
                absorb_pixel(i_pix.red, i_pix.green, i_pix.blue);
            if (i_rec.valid === 1'b1 && i_rec.ready === 1'b1) begin
                got.record_kind  = i_rec.record_kind;
                got.column_index = i_rec.column_index;
                got.channel      = i_rec.channel;
                got.mean_red     = i_rec.mean_red;
                got.mean_green   = i_rec.mean_green;
                got.mean_blue    = i_rec.mean_blue;
                got.mean_luma    = i_rec.mean_luma;
                got.stat_max     = i_rec.stat_max;
                got.stat_min     = i_rec.stat_min;
                got.stat_avg     = i_rec.stat_avg;
                got.last         = i_rec.last;
                if (profile_q.size() == 0) begin
                    note_mismatch("record with nothing expected", "none", got);
                end else begin
                    want = profile_q.pop_front();
                    if (!same_record(want, got))
                        note_mismatch("record fields differ", rec_text(want), got);
                end
            end
        end
        o_pending    <= profile_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- dv/tb_roi_column_mean_profile_stats_unit.sv -----
// Testbench top: drives pixel requests and geometry writes, paces the record sink, gives the verdict.
module tb_roi_column_mean_profile_stats_unit;
    import rcmps_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 2;
    localparam int MAX_SIDE       = 4096;
    // The block takes time at each column end and more at each region end;
    // after the last record we leave comfortably more than both.
    localparam int SETTLE_CYCLES  = 200;
    // Long enough for records to back up and the pixel input to stall.
    localparam int HOLDOFF_CYCLES = 400;
    // Cycles without any accepted request before the run is declared hung.
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_PIXELS  = 310;
    // Largest region the random part builds, in pixels.
    localparam int REGION_CAP     = 48;

    // Register indexes that the block does not decode; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // Pixel content of a region.
    typedef enum int {
        FILL_WHITE,
        FILL_BLACK,
        FILL_MIXED
    } t_fill;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    rcmps_pix_if pix_ch ();
    rcmps_rec_if rec_ch ();

    // Geometry as last written, used to size whole regions of pixel requests.
    logic [CFG_DATA_W-1:0] geo_fw;
    logic [CFG_DATA_W-1:0] geo_fh;
    logic [CFG_DATA_W-1:0] geo_left;
    logic [CFG_DATA_W-1:0] geo_top;
    logic [CFG_DATA_W-1:0] geo_cols;
    logic [CFG_DATA_W-1:0] geo_rows;

    // When set, neither side inserts gaps.
    bit calm = 1'b0;
    // The stimulus asks for a long sink hold-off; the sink process serves it.
    int holdoff_asked = 0;
    int holdoff_given = 0;
    int random_pixels = 0;
    int fail_count;
    int pending;
    int quiet_cycles  = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    roi_column_mean_profile_stats_unit #(
        .MAX_SIDE (MAX_SIDE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_ch),
        .o_rec       (rec_ch)
    );

    rcmps_profile_checker #(
        .MAX_SIDE (MAX_SIDE)
    ) u_profile_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_ch),
        .i_rec        (rec_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Length of one axis of the region after clamping to the frame.
    function automatic int unsigned clamped_len(int unsigned frame, int unsigned start,
                                                int unsigned len);
        int unsigned f;
        f = (frame < 1) ? 1 : frame;
        if (f > MAX_SIDE) f = MAX_SIDE;
        if (start > f - 1) start = f - 1;
        return (len > f - start) ? f - start : len;
    endfunction

    function automatic int unsigned region_pixels();
        return clamped_len(geo_fw, geo_left[START_W-1:0], geo_cols)
             * clamped_len(geo_fh, geo_top[START_W-1:0], geo_rows);
    endfunction

    function automatic t_fill pick_fill();
        case ($urandom_range(0, 5))
            0:       return FILL_WHITE;
            1:       return FILL_BLACK;
            default: return FILL_MIXED;
        endcase
    endfunction

    // Mixed content leans on the extremes so that the sums hit their corners.
    function automatic logic [PIX_W-1:0] level(t_fill fill);
        if (fill == FILL_WHITE) return '1;
        if (fill == FILL_BLACK) return '0;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_frame();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CFG_DATA_W'($urandom_range(1, 12));
            5, 6:          return CFG_DATA_W'(MAX_SIDE);
            7:             return '0;
            default:       return CFG_DATA_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // Starts sit in or just past small frames or just below the far edge of big ones,
    // with a share of raw 13-bit values whose top bit the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_start(logic [CFG_DATA_W-1:0] frame);
        if (frame <= 16) return CFG_DATA_W'($urandom_range(0, frame + 2));
        if ($urandom_range(0, 9) < 7) return frame - CFG_DATA_W'($urandom_range(1, 4));
        return CFG_DATA_W'($urandom_range(0, 8191));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return CFG_DATA_W'($urandom_range(1, 6));
            6, 7:             return CFG_DATA_W'($urandom_range(1, 40));
            default:          return CFG_DATA_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // One register write. The caller stands just after a rising edge; the write
    // takes effect at the next one. Write enable is left high so that writes can
    // follow back to back; the caller lowers it after the last one.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic set_region(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                              input logic [CFG_DATA_W-1:0] left,
                              input logic [CFG_DATA_W-1:0] top,
                              input logic [CFG_DATA_W-1:0] cols,
                              input logic [CFG_DATA_W-1:0] rows);
        geo_fw   = fw;
        geo_fh   = fh;
        geo_left = left;
        geo_top  = top;
        geo_cols = cols;
        geo_rows = rows;
        cfg_write(REG_FRAME_WIDTH, fw);
        cfg_write(REG_FRAME_HEIGHT, fh);
        cfg_write(REG_ROI_LEFT, left);
        cfg_write(REG_ROI_TOP, top);
        cfg_write(REG_ROI_COLUMNS, cols);
        cfg_write(REG_ROI_ROWS, rows);
        cfg_we <= 1'b0;
    endtask

    // Draws a random geometry. A non-empty region is kept small so that the
    // divider pauses stay a modest share of the run; an empty one has a zero
    // width or height.
    task automatic pick_geometry(input bit empty_region);
        logic [CFG_DATA_W-1:0] fw, fh, left, top, cols, rows;
        int unsigned           n;
        do begin
            fw   = pick_frame();
            fh   = pick_frame();
            left = pick_start(fw);
            top  = pick_start(fh);
            cols = pick_len();
            rows = pick_len();
            if (empty_region) begin
                if ($urandom_range(0, 1)) cols = '0;
                else rows = '0;
            end
            n = clamped_len(fw, left[START_W-1:0], cols)
              * clamped_len(fh, top[START_W-1:0], rows);
        end while (!empty_region && (n == 0 || n > REGION_CAP));
        set_region(fw, fh, left, top, cols, rows);
    endtask

    // Offers one pixel request, possibly after a gap, and waits for the handshake.
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        @(posedge i_clk);
        while (pix_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic send_pixels(input int n, input t_fill fill, input bit counted);
        repeat (n) begin
            send_pixel(level(fill), level(fill), level(fill));
            if (counted) random_pixels++;
        end
    endtask

    // Sender pauses until the checker has seen every record it expects. The
    // extra edge lets the pending count catch up with the last handshake.
    task automatic wait_results();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Full quiet point: no record owed and the block back at rest, so that the
    // registers may be rewritten.
    task automatic drain();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Record sink. Ready alternates between bursts and gaps; a hold-off request
    // from the stimulus makes it refuse records for a long stretch, counted here.
    initial begin : record_sink
        int n;
        rec_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (holdoff_given < holdoff_asked) begin
                rec_ch.ready <= 1'b0;
                n = HOLDOFF_CYCLES;
                holdoff_given++;
            end else if (calm || $urandom_range(0, 1)) begin
                rec_ch.ready <= 1'b1;
                n = $urandom_range(1, 24);
            end else begin
                rec_ch.ready <= 1'b0;
                n = idle_len();
            end
            repeat (n) @(posedge i_clk);
        end
    end

    // Hang detection: any accepted request on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
            (rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL roi_column_mean_profile_stats_unit");
            $finish;
        end
    end

    initial begin : stimulus
        int    phase;
        int    n;
        int    k;
        t_fill fill;

        pix_ch.valid <= 1'b0;
        pix_ch.red   <= '0;
        pix_ch.green <= '0;
        pix_ch.blue  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.

        // A one-pixel region in the far corner of the largest frame: every pixel
        // closes a column and the region, so each one yields all five records.
        set_region(13'd4096, 13'd4096, 13'd4095, 13'd4095, 13'd4096, 13'd4096);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        drain();

        // Out-of-range writes: a zero frame width saturates to one, an oversized
        // height saturates to the maximum, and starts lose their thirteenth bit.
        // The result is one column of three rows.
        set_region(13'd0, 13'd8191, 13'd8191, 13'd4098, 13'd3, 13'd3);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd1);
        drain();

        // Region that runs off the frame on both axes: three columns of two rows.
        set_region(13'd10, 13'd10, 13'd7, 13'd8, 13'd5, 13'd5);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd128, 8'd127, 8'd1);
        send_pixel(8'd3, 8'd200, 8'd77);
        drain();

        // Empty regions, zero width and then zero height: pixels are taken and
        // dropped without a record.
        set_region(13'd8, 13'd8, 13'd1, 13'd1, 13'd0, 13'd4);
        send_pixels(3, FILL_MIXED, 1'b0);
        drain();
        set_region(13'd8, 13'd8, 13'd1, 13'd1, 13'd4, 13'd0);
        send_pixels(2, FILL_MIXED, 1'b0);
        drain();

        // Two columns of two rows. A write to an unused index mid-region must not
        // disturb it; a write to a real register must throw the partial region away.
        set_region(13'd4, 13'd4, 13'd1, 13'd2, 13'd2, 13'd2);
        send_pixels(3, FILL_MIXED, 1'b0);
        drain();
        cfg_write(REG_SPARE_A, 13'h1FFF);
        cfg_we <= 1'b0;
        send_pixels(1, FILL_MIXED, 1'b0);
        send_pixels(1, FILL_WHITE, 1'b0);
        drain();
        cfg_write(REG_ROI_ROWS, 13'd2);
        cfg_we <= 1'b0;
        send_pixels(4, FILL_MIXED, 1'b0);
        drain();

        // Random part, phase by phase, each ending at a quiet point.
        phase = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            calm = ($urandom_range(0, 3) == 0);
            fill = pick_fill();
            if (phase == 1) begin
                // Six short columns while the sink holds off: records back up and
                // the block must stall the pixel input.
                calm = 1'b0;
                set_region(13'd16, 13'd8, 13'd2, 13'd3, 13'd6, 13'd2);
                holdoff_asked++;
                send_pixels(12, FILL_MIXED, 1'b1);
            end else if ($urandom_range(0, 9) == 0) begin
                pick_geometry(1'b1);
                send_pixels($urandom_range(1, 4), fill, 1'b0);
            end else begin
                pick_geometry(1'b0);
                n = region_pixels();
                repeat ($urandom_range(1, 3)) begin
                    send_pixels(n, pick_fill(), 1'b1);
                    if ($urandom_range(0, 3) == 0) wait_results();
                end
                if (n > 1 && $urandom_range(0, 4) == 0) begin
                    // Part of a region, then a quiet point. Either an ignored write
                    // and the rest of the region, or the next phase's writes drop it.
                    k = $urandom_range(1, n - 1);
                    send_pixels(k, fill, 1'b1);
                    drain();
                    if ($urandom_range(0, 1)) begin
                        cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                                  CFG_DATA_W'($urandom));
                        cfg_we <= 1'b0;
                        send_pixels(n - k, fill, 1'b1);
                    end
                end
            end
            drain();
            phase++;
        end

        calm = 1'b0;
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS roi_column_mean_profile_stats_unit");
        end else begin
            $display("FAIL roi_column_mean_profile_stats_unit");
        end
        $finish;
    end

endmodule
